### rtl/core/plinterp_pkg.sv
// ---------------------------------------------------------------------------
// plinterp_pkg
// Shared types and widths for the profile interpolator: table entry layout,
// request format passed from the front end to the back end, status groups.
// ---------------------------------------------------------------------------
`default_nettype none

package plinterp_pkg;

	localparam int HEIGHT_W = 20;
	localparam int VALUE_W  = 16;
	localparam int INDEX_W  = 5;
	localparam int COUNT_W  = 6;

	typedef struct packed {
		logic signed [HEIGHT_W-1:0] height;
		logic signed [VALUE_W-1:0]  north;
		logic signed [VALUE_W-1:0]  east;
		logic signed [VALUE_W-1:0]  temp;
	} entry_t;

	typedef struct packed {
		logic                       is_query;
		logic [INDEX_W-1:0]         index;
		entry_t                     level;
		logic signed [HEIGHT_W-1:0] query;
	} req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic holding;
		logic push;
	} front_stat_t;

	typedef struct packed {
		logic busy;
		logic pop;
	} back_stat_t;

endpackage

`default_nettype wire

### rtl/core/plinterp_front.sv
// ---------------------------------------------------------------------------
// plinterp_front
// Input stage: registers one request, classifies it as load or query and
// drops loads whose index is outside the table before they reach the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module plinterp_front #(
	parameter int MAX_LEVELS = 32
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_stall,
	input  wire logic                                     kind,
	input  wire logic [plinterp_pkg::INDEX_W-1:0]         level_index,
	input  wire logic signed [plinterp_pkg::HEIGHT_W-1:0] level_height,
	input  wire logic signed [plinterp_pkg::VALUE_W-1:0]  level_north,
	input  wire logic signed [plinterp_pkg::VALUE_W-1:0]  level_east,
	input  wire logic signed [plinterp_pkg::VALUE_W-1:0]  level_temp,
	input  wire logic signed [plinterp_pkg::HEIGHT_W-1:0] query_height,
	input  wire plinterp_pkg::queue_stat_t                q_stat,
	output plinterp_pkg::req_t                            push_req,
	output plinterp_pkg::front_stat_t                     f_stat
);
	import plinterp_pkg::*;

	logic valid_s1;
	logic keep_s1;
	req_t req_s1;
	logic accept;
	logic leave;
	logic keep;

	assign keep     = kind || (32'(level_index) < 32'(MAX_LEVELS));
	assign in_stall = valid_s1 && keep_s1 && q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign leave    = valid_s1 && (!keep_s1 || !q_stat.full);

	assign push_req       = req_s1;
	assign f_stat.holding = valid_s1;
	assign f_stat.push    = valid_s1 && keep_s1 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (leave) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			keep_s1             <= keep;
			req_s1.is_query     <= kind;
			req_s1.index        <= level_index;
			req_s1.level.height <= level_height;
			req_s1.level.north  <= level_north;
			req_s1.level.east   <= level_east;
			req_s1.level.temp   <= level_temp;
			req_s1.query        <= query_height;
		end
	end

endmodule

`default_nettype wire

### rtl/core/plinterp_queue.sv
// ---------------------------------------------------------------------------
// plinterp_queue
// Two-entry request queue between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module plinterp_queue (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire plinterp_pkg::req_t        push_req,
	input  wire logic                      pop,
	output plinterp_pkg::req_t             head_req,
	output plinterp_pkg::queue_stat_t      q_stat
);
	import plinterp_pkg::*;

	req_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head_req     = slot_q[rd_ptr_q];
	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

endmodule

`default_nettype wire

### rtl/core/plinterp_back.sv
// ---------------------------------------------------------------------------
// plinterp_back
// Execution engine: level table memory, bracket scan, serial fraction
// divider, three-lane blend and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module plinterp_back #(
	parameter int MAX_LEVELS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_wr_en,
	input  wire logic [plinterp_pkg::COUNT_W-1:0]        cfg_wr_data,
	input  wire plinterp_pkg::req_t                      head_req,
	input  wire plinterp_pkg::queue_stat_t               q_stat,
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic signed [plinterp_pkg::VALUE_W-1:0]      north_wind,
	output logic signed [plinterp_pkg::VALUE_W-1:0]      east_wind,
	output logic signed [plinterp_pkg::VALUE_W-1:0]      temperature,
	output plinterp_pkg::back_stat_t                     b_stat
);
	import plinterp_pkg::*;

	localparam int AW   = $clog2(MAX_LEVELS);
	localparam int NW   = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
	localparam int CTW  = $clog2(FRACTION_BITS);
	localparam int PW   = FRACTION_BITS + VALUE_W + 2;
	localparam int DW   = VALUE_W + 1;
	localparam int SW   = VALUE_W + 2;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LAST  = 3'd1;
	localparam logic [2:0] ST_FIRST = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_ADD   = 3'd6;

	logic [2:0]                  state_q;
	logic [COUNT_W-1:0]          level_count_q;
	entry_t                      mem_q [MAX_LEVELS];
	entry_t                      rd_data_q;
	logic [AW-1:0]               rd_addr;
	logic                        wr_en;
	logic signed [HEIGHT_W-1:0]  query_q;
	entry_t                      last_q;
	entry_t                      lo_q;
	entry_t                      hi_q;
	logic [AW-1:0]               idx_q;
	logic [HEIGHT_W-1:0]         rem_q;
	logic [HEIGHT_W-1:0]         den_q;
	logic [FRACTION_BITS-1:0]    quo_q;
	logic [CTW-1:0]              cnt_q;
	logic signed [PW-1:0]        prod_n_q;
	logic signed [PW-1:0]        prod_e_q;
	logic signed [PW-1:0]        prod_t_q;

	logic [NW-1:0]               count_ext;
	logic [NW-1:0]               n_lev;
	logic [AW-1:0]               last_addr;
	logic                        pop;
	logic                        out_free;
	logic [HEIGHT_W:0]           r2;
	logic                        ge;
	logic [HEIGHT_W:0]           r2_sub;
	logic signed [HEIGHT_W:0]    d_full;
	logic signed [HEIGHT_W:0]    den_full;
	logic signed [FRACTION_BITS:0] t_s;
	logic signed [DW-1:0]        diff_n;
	logic signed [DW-1:0]        diff_e;
	logic signed [DW-1:0]        diff_t;
	logic signed [PW-1:0]        step_n;
	logic signed [PW-1:0]        step_e;
	logic signed [PW-1:0]        step_t;
	logic signed [SW-1:0]        sum_n;
	logic signed [SW-1:0]        sum_e;
	logic signed [SW-1:0]        sum_t;

	assign count_ext = NW'(level_count_q);
	assign n_lev     = (count_ext > NW'(MAX_LEVELS)) ? NW'(MAX_LEVELS) : count_ext;
	assign last_addr = AW'(n_lev - NW'(1));

	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;
	assign wr_en    = pop && !head_req.is_query;
	assign out_free = !out_valid || !out_stall;

	assign b_stat.busy = (state_q != ST_IDLE);
	assign b_stat.pop  = pop;

	always_comb begin
		case (state_q)
			ST_LAST:  rd_addr = '0;
			ST_FIRST: rd_addr = AW'(1);
			ST_SCAN:  rd_addr = idx_q + AW'(1);
			default:  rd_addr = last_addr;
		endcase
	end

	assign r2       = {rem_q, 1'b0};
	assign ge       = (r2 >= {1'b0, den_q});
	assign r2_sub   = r2 - {1'b0, den_q};
	assign d_full   = $signed({query_q[HEIGHT_W-1], query_q})
			- $signed({lo_q.height[HEIGHT_W-1], lo_q.height});
	assign den_full = $signed({rd_data_q.height[HEIGHT_W-1], rd_data_q.height})
			- $signed({lo_q.height[HEIGHT_W-1], lo_q.height});

	assign t_s    = $signed({1'b0, quo_q});
	assign diff_n = $signed({hi_q.north[VALUE_W-1], hi_q.north})
			- $signed({lo_q.north[VALUE_W-1], lo_q.north});
	assign diff_e = $signed({hi_q.east[VALUE_W-1], hi_q.east})
			- $signed({lo_q.east[VALUE_W-1], lo_q.east});
	assign diff_t = $signed({hi_q.temp[VALUE_W-1], hi_q.temp})
			- $signed({lo_q.temp[VALUE_W-1], lo_q.temp});

	assign step_n = prod_n_q >>> FRACTION_BITS;
	assign step_e = prod_e_q >>> FRACTION_BITS;
	assign step_t = prod_t_q >>> FRACTION_BITS;
	assign sum_n  = SW'(lo_q.north) + step_n[SW-1:0];
	assign sum_e  = SW'(lo_q.east) + step_e[SW-1:0];
	assign sum_t  = SW'(lo_q.temp) + step_t[SW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[AW'(head_req.index)] <= head_req.level;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= '0;
		end else if (cfg_wr_en) begin
			level_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && head_req.is_query) begin
						state_q <= (n_lev == '0) ? ST_MUL : ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_FIRST;
				end
				ST_FIRST: begin
					if (($signed(query_q) <= $signed(rd_data_q.height))
							|| ($signed(query_q) >= $signed(last_q.height))) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if ($signed(query_q) < $signed(rd_data_q.height)) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == CTW'(FRACTION_BITS - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				query_q <= head_req.query;
				lo_q    <= '0;
				hi_q    <= '0;
				quo_q   <= '0;
			end
			ST_LAST: begin
				last_q <= rd_data_q;
			end
			ST_FIRST: begin
				quo_q <= '0;
				idx_q <= AW'(1);
				if ($signed(query_q) <= $signed(rd_data_q.height)) begin
					lo_q <= rd_data_q;
					hi_q <= rd_data_q;
				end else if ($signed(query_q) >= $signed(last_q.height)) begin
					lo_q <= last_q;
					hi_q <= last_q;
				end else begin
					lo_q <= rd_data_q;
				end
			end
			ST_SCAN: begin
				if ($signed(query_q) < $signed(rd_data_q.height)) begin
					hi_q  <= rd_data_q;
					rem_q <= d_full[HEIGHT_W-1:0];
					den_q <= den_full[HEIGHT_W-1:0];
					cnt_q <= '0;
				end else begin
					lo_q  <= rd_data_q;
					idx_q <= idx_q + AW'(1);
				end
			end
			ST_DIV: begin
				rem_q <= ge ? r2_sub[HEIGHT_W-1:0] : r2[HEIGHT_W-1:0];
				quo_q <= {quo_q[FRACTION_BITS-2:0], ge};
				cnt_q <= cnt_q + CTW'(1);
			end
			ST_MUL: begin
				prod_n_q <= PW'(t_s) * PW'(diff_n);
				prod_e_q <= PW'(t_s) * PW'(diff_e);
				prod_t_q <= PW'(t_s) * PW'(diff_t);
			end
			ST_ADD: begin
				if (out_free) begin
					north_wind  <= sum_n[VALUE_W-1:0];
					east_wind   <= sum_e[VALUE_W-1:0];
					temperature <= sum_t[VALUE_W-1:0];
				end
			end
			default: begin
				quo_q <= '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/profile_linear_interpolator.sv
// ---------------------------------------------------------------------------
// profile_linear_interpolator
// Piecewise linear lookup of wind and temperature over a table of levels.
//
// Input channel (in_valid / in_stall): kind 0 loads level_index with height,
// north, east and temperature; kind 1 queries at query_height. Loads give no
// result; each query gives one result on the output channel
// (out_valid / out_stall). cfg_wr_en writes level_count; the user must write
// it only while idle, as the block does not enforce this. A request passes
// an input register and a two-entry queue, so the input keeps taking requests
// while the back end works or the output is stalled, until both are full.
// Back end: a load writes the table; a query reads the last and first levels
// (skipped on an empty table), an interior one then scans from level 1 to the
// bracketing level (one table memory read per cycle) and runs the serial
// FRACTION_BITS-bit divider; each query ends in multiply and add. The back
// end takes a request only when idle, so scan and divider set the sustained
// rate. A result waits in the output register while out_stall is high; the
// back end holds its next result until that register frees. Reset zeroes the
// count and empties the pipeline; table contents are undefined until loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module profile_linear_interpolator #(
	parameter int MAX_LEVELS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_stall,
	input  wire logic                                     kind,
	input  wire logic [plinterp_pkg::INDEX_W-1:0]         level_index,
	input  wire logic signed [plinterp_pkg::HEIGHT_W-1:0] level_height,
	input  wire logic signed [plinterp_pkg::VALUE_W-1:0]  level_north,
	input  wire logic signed [plinterp_pkg::VALUE_W-1:0]  level_east,
	input  wire logic signed [plinterp_pkg::VALUE_W-1:0]  level_temp,
	input  wire logic signed [plinterp_pkg::HEIGHT_W-1:0] query_height,
	input  wire logic                                     cfg_wr_en,
	input  wire logic [plinterp_pkg::COUNT_W-1:0]         cfg_wr_data,
	output logic                                          out_valid,
	input  wire logic                                     out_stall,
	output logic signed [plinterp_pkg::VALUE_W-1:0]       north_wind,
	output logic signed [plinterp_pkg::VALUE_W-1:0]       east_wind,
	output logic signed [plinterp_pkg::VALUE_W-1:0]       temperature
);
	import plinterp_pkg::*;

	req_t        push_req;
	req_t        head_req;
	queue_stat_t q_stat;
	front_stat_t f_stat;
	back_stat_t  b_stat;

	plinterp_front #(
		.MAX_LEVELS (MAX_LEVELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.level_index  (level_index),
		.level_height (level_height),
		.level_north  (level_north),
		.level_east   (level_east),
		.level_temp   (level_temp),
		.query_height (query_height),
		.q_stat       (q_stat),
		.push_req     (push_req),
		.f_stat       (f_stat)
	);

	plinterp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_stat.push),
		.push_req (push_req),
		.pop      (b_stat.pop),
		.head_req (head_req),
		.q_stat   (q_stat)
	);

	plinterp_back #(
		.MAX_LEVELS    (MAX_LEVELS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.head_req    (head_req),
		.q_stat      (q_stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.north_wind  (north_wind),
		.east_wind   (east_wind),
		.temperature (temperature),
		.b_stat      (b_stat)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		f_stat.push |-> !q_stat.full)
		else $error("request pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.pop |-> !q_stat.empty)
		else $error("request popped from empty queue");

	a_result_from_engine: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(b_stat.busy))
		else $error("result raised without an active query");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (f_stat.holding && q_stat.full))
		else $error("input stalled with room in queue");

endmodule

`default_nettype wire
